[rtl/per_source_volume_top_k_unit_defines.svh]
// assertion macros for the per-source volume top-k unit
`ifndef PER_SOURCE_VOLUME_TOP_K_UNIT_DEFINES_SVH
`define PER_SOURCE_VOLUME_TOP_K_UNIT_DEFINES_SVH

// clocked check, held off during reset
`define PSV_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked over the same clock edge
`define PSV_IMPLIES(lbl, ante, cons, msg) \
  `PSV_CHECK(lbl, (ante) |-> (cons), msg)

`endif

[rtl/psv_pkg.sv]
// shared constants and types for the per-source volume top-k unit
`default_nettype none
package psv_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int TopCount   = 10;
  localparam int RankW      = 4;
  localparam int AddrW      = 32;
  localparam int LenW       = 16;
  localparam int PktW       = 32;
  localparam int ByteW      = 48;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic             is_report;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] key;
    logic [PktW-1:0]  pkts;
    logic [ByteW-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] used;
  } status_t;
endpackage
`default_nettype wire

[rtl/psv_front.sv]
// input side: accepts items, classifies them and queues them for the table engine
`default_nettype none
module psv_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     operation,
  input  wire logic [psv_pkg::AddrW-1:0] src_addr,
  input  wire logic [psv_pkg::LenW-1:0]  ip_length,
  output logic                          q_valid,
  output psv_pkg::item_t                q_item,
  input  wire logic                     q_pop
);
  psv_pkg::item_t                slot [psv_pkg::QueueDepth];
  logic [psv_pkg::QPtrW-1:0]     wr_ptr;
  logic [psv_pkg::QPtrW-1:0]     rd_ptr;
  logic [psv_pkg::QCntW-1:0]     count;
  logic                          push;
  logic                          pop;

  assign in_ready = (count != psv_pkg::QCntW'(psv_pkg::QueueDepth));
  assign q_valid  = (count != '0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].is_report <= (operation == psv_pkg::OP_REPORT);
      slot[wr_ptr].addr      <= src_addr;
      slot[wr_ptr].len       <= ip_length;
    end
  end
endmodule
`default_nettype wire

[rtl/psv_back.sv]
// table engine: address search, counter update, top-k selection and result register
`default_nettype none
module psv_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire psv_pkg::item_t             q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [psv_pkg::RankW-1:0]       rank,
  output logic [psv_pkg::AddrW-1:0]       entry_addr,
  output logic [psv_pkg::PktW-1:0]        packet_total,
  output logic [psv_pkg::ByteW-1:0]       byte_total,
  output logic                            entry_valid,
  output logic                            table_full_drop,
  output logic                            last,
  output psv_pkg::status_t                status
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LREAD  = 3'd1;
  localparam logic [2:0] S_LCHECK = 3'd2;
  localparam logic [2:0] S_RREAD  = 3'd3;
  localparam logic [2:0] S_RCHECK = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam logic [1:0] RES_ENTRY = 2'd0;
  localparam logic [1:0] RES_DROP  = 2'd1;
  localparam logic [1:0] RES_EMPTY = 2'd2;

  psv_pkg::entry_t                mem [psv_pkg::TableDepth];
  psv_pkg::entry_t                rd_data;
  logic                           we;
  logic [psv_pkg::IdxW-1:0]       wr_idx;
  psv_pkg::entry_t                wr_data;

  logic [2:0]                     state;
  logic [psv_pkg::CntW-1:0]       used;
  logic [psv_pkg::IdxW-1:0]       idx;
  logic [psv_pkg::AddrW-1:0]      cur_addr;
  logic [psv_pkg::LenW-1:0]       cur_len;
  logic                           have_prev;
  logic [psv_pkg::ByteW-1:0]      prev_bytes;
  logic [psv_pkg::IdxW-1:0]       prev_idx;
  logic                           found;
  psv_pkg::entry_t                best;
  logic [psv_pkg::IdxW-1:0]       best_idx;
  logic [psv_pkg::RankW-1:0]      rank_cnt;
  logic [1:0]                     res_kind;

  logic                           at_end;
  logic                           hit;
  logic                           table_full;
  logic                           eligible;
  logic                           better;
  logic                           space;
  logic                           is_last;
  logic                           emit;
  logic [psv_pkg::ByteW:0]        byte_sum;
  psv_pkg::entry_t                fresh;

  assign at_end     = (psv_pkg::CntW'(idx) + 1'b1 == used);
  assign hit        = (rd_data.key == cur_addr);
  assign table_full = (used == psv_pkg::CntW'(psv_pkg::TableDepth));
  assign eligible   = !have_prev || (rd_data.bytes < prev_bytes) ||
                      ((rd_data.bytes == prev_bytes) && (idx > prev_idx));
  assign better     = eligible && (!found || (rd_data.bytes > best.bytes));
  assign space      = !out_valid || out_ready;
  assign is_last    = (rank_cnt == psv_pkg::RankW'(psv_pkg::TopCount - 1)) ||
                      (psv_pkg::CntW'(rank_cnt) + 1'b1 == used);
  assign emit       = (state == S_EMIT) && space;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign byte_sum   = {1'b0, rd_data.bytes} + (psv_pkg::ByteW + 1)'(cur_len);
  assign status     = '{busy: (state != S_IDLE), used: used};

  always_comb begin
    fresh = '{key: cur_addr, pkts: psv_pkg::PktW'(1),
              bytes: psv_pkg::ByteW'(cur_len)};
    we      = 1'b0;
    wr_idx  = idx;
    wr_data = fresh;
    case (state)
      S_IDLE: begin
        if (q_pop && !q_item.is_report && (used == '0)) begin
          we      = 1'b1;
          wr_idx  = '0;
          wr_data = '{key: q_item.addr, pkts: psv_pkg::PktW'(1),
                      bytes: psv_pkg::ByteW'(q_item.len)};
        end
      end
      S_LCHECK: begin
        if (hit) begin
          we            = 1'b1;
          wr_data.key   = rd_data.key;
          wr_data.pkts  = (&rd_data.pkts) ? rd_data.pkts : rd_data.pkts + 1'b1;
          wr_data.bytes = byte_sum[psv_pkg::ByteW] ? {psv_pkg::ByteW{1'b1}}
                                                   : byte_sum[psv_pkg::ByteW-1:0];
        end else if (at_end && !table_full) begin
          we     = 1'b1;
          wr_idx = used[psv_pkg::IdxW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_idx] <= wr_data;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.is_report) begin
              state <= (used == '0) ? S_EMIT : S_RREAD;
            end else if (used == '0) begin
              used <= used + 1'b1;
            end else begin
              state <= S_LREAD;
            end
          end
        end
        S_LREAD:  state <= S_LCHECK;
        S_LCHECK: begin
          if (hit) begin
            state <= S_IDLE;
          end else if (at_end) begin
            if (table_full) begin
              state <= S_EMIT;
            end else begin
              used  <= used + 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_LREAD;
          end
        end
        S_RREAD:  state <= S_RCHECK;
        S_RCHECK: state <= at_end ? S_EMIT : S_RREAD;
        S_EMIT: begin
          if (space) state <= ((res_kind == RES_ENTRY) && !is_last) ? S_RREAD : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          cur_addr  <= q_item.addr;
          cur_len   <= q_item.len;
          idx       <= '0;
          have_prev <= 1'b0;
          found     <= 1'b0;
          rank_cnt  <= '0;
          res_kind  <= q_item.is_report ? ((used == '0) ? RES_EMPTY : RES_ENTRY)
                                        : RES_DROP;
        end
      end
      S_LCHECK: begin
        if (!hit && !at_end) idx <= idx + 1'b1;
      end
      S_RCHECK: begin
        if (better) begin
          best     <= rd_data;
          best_idx <= idx;
          found    <= 1'b1;
        end
        if (!at_end) idx <= idx + 1'b1;
      end
      S_EMIT: begin
        if (space) begin
          idx        <= '0;
          found      <= 1'b0;
          have_prev  <= 1'b1;
          prev_bytes <= best.bytes;
          prev_idx   <= best_idx;
          rank_cnt   <= rank_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      case (res_kind)
        RES_ENTRY: begin
          rank            <= rank_cnt;
          entry_addr      <= best.key;
          packet_total    <= best.pkts;
          byte_total      <= best.bytes;
          entry_valid     <= 1'b1;
          table_full_drop <= 1'b0;
          last            <= is_last;
        end
        default: begin
          rank            <= '0;
          entry_addr      <= '0;
          packet_total    <= '0;
          byte_total      <= '0;
          entry_valid     <= 1'b0;
          table_full_drop <= (res_kind == RES_DROP);
          last            <= 1'b1;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/per_source_volume_top_k_unit.sv]
// Per-source volume counter with top-k report.
// Input channel (in_valid/in_ready): operation selects counting a packet
// (src_addr, ip_length) or a report of the largest byte volumes.
// Output channel (out_valid/out_ready): result records; last marks the
// final record of an item. A counted packet gives no record; a packet
// missing a full table gives one drop record; a report gives up to ten
// records in descending byte order, or one empty record.
// A two-entry queue takes items while the table engine works. A packet
// is looked up among the n entries in use one entry at a time, read in
// S_LREAD and compared in S_LCHECK, via a single registered read port.
// A report makes one full table pass per record.
// Results sit in an output register; while the receiver stalls the engine
// waits and the queue keeps taking items until it is full.
// Reset empties the table and the queue; no clearing pass is needed.
`default_nettype none
`include "per_source_volume_top_k_unit_defines.svh"
module per_source_volume_top_k_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       operation,
  input  wire logic [psv_pkg::AddrW-1:0]  src_addr,
  input  wire logic [psv_pkg::LenW-1:0]   ip_length,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [psv_pkg::RankW-1:0]       rank,
  output logic [psv_pkg::AddrW-1:0]       entry_addr,
  output logic [psv_pkg::PktW-1:0]        packet_total,
  output logic [psv_pkg::ByteW-1:0]       byte_total,
  output logic                            entry_valid,
  output logic                            table_full_drop,
  output logic                            last
);
  logic             q_valid;
  psv_pkg::item_t   q_item;
  logic             q_pop;
  psv_pkg::status_t status;

  psv_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .src_addr(src_addr), .ip_length(ip_length),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  psv_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .rank(rank), .entry_addr(entry_addr), .packet_total(packet_total),
    .byte_total(byte_total), .entry_valid(entry_valid),
    .table_full_drop(table_full_drop), .last(last),
    .status(status)
  );

  `PSV_CHECK(a_used_bound, status.used <= psv_pkg::CntW'(psv_pkg::TableDepth), "fill count overrun")
  `PSV_IMPLIES(a_drop_full, out_valid && table_full_drop, status.used == psv_pkg::CntW'(psv_pkg::TableDepth), "drop while table has room")
  `PSV_IMPLIES(a_drop_kind, out_valid && entry_valid, !table_full_drop, "entry record flagged as drop")
  `PSV_IMPLIES(a_pop_idle, q_pop, !status.busy, "queue popped while engine busy")
endmodule
`default_nettype wire
